[rtl/core/rri_pkg.sv]
package rri_pkg;

	localparam int COORD_W   = 16;
	localparam int UNIT_W    = 16;
	localparam int DIST_W    = 24;
	localparam int EXT_W     = 16;
	localparam int ID_W      = 16;
	localparam int DIV_STEPS = 24;
	localparam int QDEPTH    = 8;
	localparam int QADDR_W   = 3;
	localparam int QCNT_W    = 4;
	localparam int PAR_LIMIT = 3;

	typedef logic [2:0][UNIT_W-1:0] vec_t;

	typedef enum logic [2:0] {
		REG_ENABLE   = 3'd0,
		REG_CENTER   = 3'd1,
		REG_NORMAL   = 3'd2,
		REG_AXIS_U   = 3'd3,
		REG_AXIS_V   = 3'd4,
		REG_HALF     = 3'd5,
		REG_OBJECT   = 3'd6,
		REG_MATERIAL = 3'd7
	} reg_e;

	typedef struct packed {
		logic             enable;
		vec_t             c;
		vec_t             n;
		vec_t             u;
		vec_t             v;
		logic [EXT_W-1:0] half_u;
		logic [EXT_W-1:0] half_v;
		logic [ID_W-1:0]  obj;
		logic [ID_W-1:0]  mat;
	} cfg_t;

	// One classified ray handed from the front end to the back end.
	typedef struct packed {
		logic              kill;
		logic [33:0]       num;
		logic [32:0]       den;
		vec_t              o;
		vec_t              d;
		vec_t              f;
		logic [DIST_W-1:0] near;
	} job_t;

endpackage

[rtl/core/rri_ifs.sv]
interface rri_ray_if;
	logic        valid;
	logic        ready;
	logic [15:0] origin_x;
	logic [15:0] origin_y;
	logic [15:0] origin_z;
	logic [15:0] dir_x;
	logic [15:0] dir_y;
	logic [15:0] dir_z;
	logic [23:0] nearest_distance;
	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		nearest_distance, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		nearest_distance, output ready);
endinterface

interface rri_res_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [23:0] hit_distance;
	logic [15:0] hit_x;
	logic [15:0] hit_y;
	logic [15:0] hit_z;
	logic [15:0] facing_nx;
	logic [15:0] facing_ny;
	logic [15:0] facing_nz;
	logic [15:0] hit_object;
	logic [15:0] hit_material;
	modport source (output valid, hit, hit_distance, hit_x, hit_y, hit_z, facing_nx,
		facing_ny, facing_nz, hit_object, hit_material, input ready);
	modport sink (input valid, hit, hit_distance, hit_x, hit_y, hit_z, facing_nx,
		facing_ny, facing_nz, hit_object, hit_material, output ready);
endinterface

[rtl/core/rri_queue.sv]
module rri_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  rri_pkg::job_t               wdata,
	input  logic                        pop,
	output rri_pkg::job_t               rdata,
	output logic                        empty,
	output logic [rri_pkg::QCNT_W-1:0]  count
);
	import rri_pkg::*;

	job_t               mem [QDEPTH];
	logic [QADDR_W-1:0] wptr_q;
	logic [QADDR_W-1:0] rptr_q;
	logic [QCNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wptr_q] <= wdata;
	end

	assign rdata = mem[rptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

[rtl/core/rri_front.sv]
module rri_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rri_pkg::cfg_t              cfg,
	rri_ray_if.sink                    ray,
	input  logic [rri_pkg::QCNT_W-1:0] q_count,
	output logic                       push,
	output rri_pkg::job_t              job
);
	import rri_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	vec_t o_s1, d_s1, o_s2, d_s2, f_s2, o_s3, d_s3, f_s3, o_s4, d_s4, f_s4;
	logic [DIST_W-1:0] near_s1, near_s2, near_s3, near_s4;
	logic signed [31:0] pn_s1 [3];
	logic signed [16:0] oc_s2 [3];
	logic signed [31:0] pd_s3 [3];
	logic signed [32:0] pf_s3 [3];
	logic signed [33:0] den_s4;
	logic signed [34:0] num_s4;

	vec_t               o_in, d_in, f_c;
	logic signed [31:0] pn_c [3];
	logic signed [33:0] dn_c;
	logic signed [16:0] oc_c [3];
	logic signed [31:0] pd_c [3];
	logic signed [32:0] pf_c [3];
	logic [2:0]         inflight;
	logic [QCNT_W:0]    used;
	logic signed [40:0] den_x64;
	logic               kill;

	assign o_in = {ray.origin_z, ray.origin_y, ray.origin_x};
	assign d_in = {ray.dir_z, ray.dir_y, ray.dir_x};

	// Items in flight are counted against free queue slots, so the front never stalls.
	assign inflight  = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign used      = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(inflight);
	assign ray.ready = (used < (QCNT_W+1)'(QDEPTH));

	always_comb begin
		dn_c = 34'(pn_s1[0]) + 34'(pn_s1[1]) + 34'(pn_s1[2]);
		for (int i = 0; i < 3; i++) begin
			pn_c[i] = $signed(d_in[i]) * $signed(cfg.n[i]);
			oc_c[i] = 17'($signed(o_s1[i])) - 17'($signed(cfg.c[i]));
			if (dn_c > 0) begin
				f_c[i] = (cfg.n[i] == 16'h8000) ? 16'h7fff : 16'(-$signed(cfg.n[i]));
			end else begin
				f_c[i] = cfg.n[i];
			end
			pd_c[i] = $signed(d_s2[i]) * $signed(f_s2[i]);
			pf_c[i] = $signed(f_s2[i]) * oc_s2[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ray.valid && ray.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		o_s1    <= o_in;
		d_s1    <= d_in;
		near_s1 <= ray.nearest_distance;
		pn_s1   <= pn_c;
		o_s2    <= o_s1;
		d_s2    <= d_s1;
		near_s2 <= near_s1;
		f_s2    <= f_c;
		oc_s2   <= oc_c;
		o_s3    <= o_s2;
		d_s3    <= d_s2;
		f_s3    <= f_s2;
		near_s3 <= near_s2;
		pd_s3   <= pd_c;
		pf_s3   <= pf_c;
		o_s4    <= o_s3;
		d_s4    <= d_s3;
		f_s4    <= f_s3;
		near_s4 <= near_s3;
		den_s4  <= -(34'(pd_s3[0]) + 34'(pd_s3[1]) + 34'(pd_s3[2]));
		num_s4  <= 35'(pf_s3[0]) + 35'(pf_s3[1]) + 35'(pf_s3[2]);
	end

	// A distance of 2^24 LSBs or more can never beat the nearest hit, so such rays are
	// dropped here and the divider only needs 24 quotient bits.
	assign den_x64 = 41'(den_s4) <<< 6;
	assign kill = !cfg.enable || (den_s4 < 34'sd3) || (num_s4 <= 35'sd0) ||
		(41'(num_s4) >= den_x64);

	assign push     = v_s4;
	assign job.kill = kill;
	assign job.num  = num_s4[33:0];
	assign job.den  = den_s4[32:0];
	assign job.o    = o_s4;
	assign job.d    = d_s4;
	assign job.f    = f_s4;
	assign job.near = near_s4;

endmodule

[rtl/core/rri_back.sv]
module rri_back (
	input  logic          clk,
	input  logic          arst_n,
	input  rri_pkg::cfg_t cfg,
	input  rri_pkg::job_t job,
	input  logic          q_empty,
	output logic          pop,
	rri_res_if.source     res
);
	import rri_pkg::*;

	typedef struct packed {
		logic              kill;
		logic [33:0]       rem;
		logic [32:0]       den;
		logic [5:0]        nlo;
		logic [DIST_W-1:0] q;
		vec_t              o;
		vec_t              d;
		vec_t              f;
		logic [DIST_W-1:0] near;
	} dst_t;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	function automatic dst_t div_step(dst_t a);
		logic [34:0] t;
		dst_t        r;
		r     = a;
		t     = {a.rem, a.nlo[5]};
		r.nlo = {a.nlo[4:0], 1'b0};
		if (t >= {2'b00, a.den}) begin
			r.rem = 34'(t - {2'b00, a.den});
			r.q   = {a.q[DIST_W-2:0], 1'b1};
		end else begin
			r.rem = t[33:0];
			r.q   = {a.q[DIST_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic adv;
	logic dv_s [DIV_STEPS+1];
	dst_t ds_s [DIV_STEPS+1];
	dst_t load;

	logic v_s1, v_s2, v_s3, v_s4, ov_q;
	logic kill_s1, kill_s2, kill_s3, kill_s4;
	logic [DIST_W-1:0] q_s1, q_s2, q_s3, q_s4;
	vec_t o_s1, f_s1, f_s2, f_s3, f_s4;
	logic signed [40:0] pq_s1 [3];
	logic signed [24:0] p_s2 [3];
	logic signed [24:0] p_s3 [3];
	logic signed [24:0] p_s4 [3];
	logic signed [25:0] pc_s2 [3];
	logic signed [41:0] mu_s3 [3];
	logic signed [41:0] mv_s3 [3];
	logic signed [43:0] pu_s4, pv_s4;

	logic signed [40:0] t1;
	logic signed [16:0] t2;
	logic signed [24:0] p_c [3];
	logic signed [25:0] pc_c [3];
	logic signed [43:0] lu, lv;
	logic               in_rect, hit_c;
	logic [15:0]        ps_c [3];

	assign adv = !ov_q || res.ready;
	assign pop = adv && !q_empty;

	always_comb begin
		load      = '0;
		load.kill = job.kill;
		load.rem  = {6'b0, job.num[33:6]};
		load.den  = job.den;
		load.nlo  = job.num[5:0];
		load.o    = job.o;
		load.d    = job.d;
		load.f    = job.f;
		load.near = job.near;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) dv_s[k] <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			dv_s[0] <= pop;
			for (int k = 0; k < DIV_STEPS; k++) dv_s[k+1] <= dv_s[k];
			v_s1 <= dv_s[DIV_STEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			ov_q <= v_s4;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t1 = (pq_s1[i] + 41'sd131072) >>> 18;
			t2 = (17'($signed(f_s1[i])) + 17'sd8192) >>> 14;
			p_c[i]  = 25'($signed(o_s1[i])) + $signed(t1[24:0]) + 25'(t2);
			pc_c[i] = 26'(p_c[i]) - 26'($signed(cfg.c[i]));
		end
		lu      = $signed({14'b0, cfg.half_u, 14'b0});
		lv      = $signed({14'b0, cfg.half_v, 14'b0});
		in_rect = (pu_s4 <= lu) && (pu_s4 >= -lu) && (pv_s4 <= lv) && (pv_s4 >= -lv);
		hit_c   = !kill_s4 && in_rect;
		for (int i = 0; i < 3; i++) begin
			if (p_s4[i] > 25'sd32767) ps_c[i] = 16'h7fff;
			else if (p_s4[i] < -25'sd32768) ps_c[i] = 16'h8000;
			else ps_c[i] = p_s4[i][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ds_s[0] <= load;
			for (int k = 0; k < DIV_STEPS; k++) ds_s[k+1] <= div_step(ds_s[k]);

			kill_s1 <= ds_s[DIV_STEPS].kill || (ds_s[DIV_STEPS].q == '0) ||
				(ds_s[DIV_STEPS].q >= ds_s[DIV_STEPS].near);
			q_s1 <= ds_s[DIV_STEPS].q;
			o_s1 <= ds_s[DIV_STEPS].o;
			f_s1 <= ds_s[DIV_STEPS].f;
			for (int i = 0; i < 3; i++) begin
				pq_s1[i] <= $signed({1'b0, ds_s[DIV_STEPS].q}) *
					$signed(ds_s[DIV_STEPS].d[i]);
			end

			kill_s2 <= kill_s1;
			q_s2    <= q_s1;
			f_s2    <= f_s1;
			p_s2    <= p_c;
			pc_s2   <= pc_c;

			kill_s3 <= kill_s2;
			q_s3    <= q_s2;
			f_s3    <= f_s2;
			p_s3    <= p_s2;
			for (int i = 0; i < 3; i++) begin
				mu_s3[i] <= $signed(cfg.u[i]) * pc_s2[i];
				mv_s3[i] <= $signed(cfg.v[i]) * pc_s2[i];
			end

			kill_s4 <= kill_s3;
			q_s4    <= q_s3;
			f_s4    <= f_s3;
			p_s4    <= p_s3;
			pu_s4   <= 44'(mu_s3[0]) + 44'(mu_s3[1]) + 44'(mu_s3[2]);
			pv_s4   <= 44'(mv_s3[0]) + 44'(mv_s3[1]) + 44'(mv_s3[2]);

			res.hit          <= hit_c;
			res.hit_distance <= hit_c ? q_s4 : '0;
			res.hit_x        <= hit_c ? ps_c[0] : '0;
			res.hit_y        <= hit_c ? ps_c[1] : '0;
			res.hit_z        <= hit_c ? ps_c[2] : '0;
			res.facing_nx    <= hit_c ? f_s4[0] : '0;
			res.facing_ny    <= hit_c ? f_s4[1] : '0;
			res.facing_nz    <= hit_c ? f_s4[2] : '0;
			res.hit_object   <= hit_c ? cfg.obj : '0;
			res.hit_material <= hit_c ? cfg.mat : '0;
		end
	end

	assign res.valid = ov_q;

endmodule

[rtl/core/ray_rectangle_intersect.sv]
// Ray against rectangle test, fully pipelined: one ray per cycle sustained while the
// output is not stalled. A result passes the four front stages, the queue write, the
// divider load stage and its 24 steps, four hit point and extent stages and the
// output register. A stalled output halts only the back end; the front takes rays while
// its four stages plus the eight-entry queue hold fewer than eight rays.
// Reset clears all valid bits, queue pointers and the configuration registers.
module ray_rectangle_intersect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	rri_ray_if.sink     ray,
	rri_res_if.source   res
);
	import rri_pkg::*;

	cfg_t              cfg_q;
	logic              wr;
	reg_e              sel;
	logic              push, pop, q_empty;
	job_t              job_in, job_out;
	logic [QCNT_W-1:0] q_count;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign sel    = reg_e'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (sel)
				REG_ENABLE:   cfg_q.enable <= pwdata[0];
				REG_CENTER:   cfg_q.c      <= pwdata[47:0];
				REG_NORMAL:   cfg_q.n      <= pwdata[47:0];
				REG_AXIS_U:   cfg_q.u      <= pwdata[47:0];
				REG_AXIS_V:   cfg_q.v      <= pwdata[47:0];
				REG_HALF: begin
					cfg_q.half_u <= pwdata[15:0];
					cfg_q.half_v <= pwdata[31:16];
				end
				REG_OBJECT:   cfg_q.obj    <= pwdata[15:0];
				REG_MATERIAL: cfg_q.mat    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_ENABLE:   prdata = {63'b0, cfg_q.enable};
			REG_CENTER:   prdata = {16'b0, cfg_q.c};
			REG_NORMAL:   prdata = {16'b0, cfg_q.n};
			REG_AXIS_U:   prdata = {16'b0, cfg_q.u};
			REG_AXIS_V:   prdata = {16'b0, cfg_q.v};
			REG_HALF:     prdata = {32'b0, cfg_q.half_v, cfg_q.half_u};
			REG_OBJECT:   prdata = {48'b0, cfg_q.obj};
			REG_MATERIAL: prdata = {48'b0, cfg_q.mat};
			default:      prdata = '0;
		endcase
	end

	rri_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.ray     (ray),
		.q_count (q_count),
		.push    (push),
		.job     (job_in)
	);

	rri_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.empty  (q_empty),
		.count  (q_count)
	);

	rri_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.job     (job_out),
		.q_empty (q_empty),
		.pop     (pop),
		.res     (res)
	);

	// The credit scheme in the front must keep the queue from overflowing.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> q_count < QCNT_W'(QDEPTH))
		else $error("queue written while full");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |-> res.hit_distance == '0 && res.hit_object == '0 &&
			res.facing_nx == '0 && res.hit_x == '0)
		else $error("miss result carries nonzero fields");

	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.hit |-> res.hit_distance != '0)
		else $error("hit reported with zero distance");

endmodule

[test/ray_rectangle_intersect_test.sv]
module ray_rectangle_intersect_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rri_pkg::*;

	typedef struct packed {
		logic [15:0] ox;
		logic [15:0] oy;
		logic [15:0] oz;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [15:0] dz;
		logic [23:0] nearest;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [23:0] distance;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pz;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [15:0] obj;
		logic [15:0] mat;
	} hit_t;

	class rect_scoreboard;
		bit          en;
		longint      c[3], n[3], u[3], v[3];
		longint      half_u, half_v;
		logic [15:0] obj, mat;
		hit_t        pending_hits[$];
		int          errors;

		function void set_reg(reg_e idx, logic [63:0] val);
			case (idx)
				REG_ENABLE:   en = val[0];
				REG_CENTER:   for (int i = 0; i < 3; i++) c[i] = $signed(val[16*i +: 16]);
				REG_NORMAL:   for (int i = 0; i < 3; i++) n[i] = $signed(val[16*i +: 16]);
				REG_AXIS_U:   for (int i = 0; i < 3; i++) u[i] = $signed(val[16*i +: 16]);
				REG_AXIS_V:   for (int i = 0; i < 3; i++) v[i] = $signed(val[16*i +: 16]);
				REG_HALF: begin
					half_u = val[15:0];
					half_v = val[31:16];
				end
				REG_OBJECT:   obj = val[15:0];
				REG_MATERIAL: mat = val[15:0];
				default: ;
			endcase
		endfunction

		static function longint sat16(longint x);
			if (x > 32767) return 32767;
			if (x < -32768) return -32768;
			return x;
		endfunction

		// Works out the hit record for one accepted ray.
		function void note_ray(ray_t r);
			longint o[3], d[3], f[3], p[3];
			longint dn, den, num, q0, rem, q, pu, pv;
			hit_t e;
			bit ok;
			e = '0;
			ok = en;
			o[0] = $signed(r.ox); o[1] = $signed(r.oy); o[2] = $signed(r.oz);
			d[0] = $signed(r.dx); d[1] = $signed(r.dy); d[2] = $signed(r.dz);
			dn = 0; den = 0; num = 0; pu = 0; pv = 0; q = 0;
			for (int i = 0; i < 3; i++) dn += d[i] * n[i];
			for (int i = 0; i < 3; i++) f[i] = (dn > 0) ? sat16(-n[i]) : n[i];
			for (int i = 0; i < 3; i++) den -= d[i] * f[i];
			if (den < PAR_LIMIT) ok = 0;
			for (int i = 0; i < 3; i++) num += f[i] * (o[i] - c[i]);
			if (ok && num <= 0) ok = 0;
			if (ok) begin
				q0 = num / den;
				if (q0 >= 4096) ok = 0;
				rem = num % den;
				q = q0 * (64'sd1 << 18) + (rem * (64'sd1 << 18)) / den;
				if (q == 0 || q >= longint'(r.nearest)) ok = 0;
			end
			if (ok) begin
				for (int i = 0; i < 3; i++)
					p[i] = o[i] + ((q * d[i] + (64'sd1 << 17)) >>> 18)
						+ ((f[i] + (64'sd1 << 13)) >>> 14);
				for (int i = 0; i < 3; i++) begin
					pu += u[i] * (p[i] - c[i]);
					pv += v[i] * (p[i] - c[i]);
				end
				if (pu < -(half_u << 14) || pu > (half_u << 14)) ok = 0;
				if (pv < -(half_v << 14) || pv > (half_v << 14)) ok = 0;
			end
			if (ok) begin
				e.hit = 1'b1;
				e.distance = q[23:0];
				e.px = 16'(sat16(p[0]));
				e.py = 16'(sat16(p[1]));
				e.pz = 16'(sat16(p[2]));
				e.nx = 16'(f[0]);
				e.ny = 16'(f[1]);
				e.nz = 16'(f[2]);
				e.obj = obj;
				e.mat = mat;
			end
			pending_hits.push_back(e);
		endfunction

		function void cmp(string name, logic [23:0] exp_v, logic [23:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(hit_t a);
			hit_t e;
			if (pending_hits.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $realtime, a);
				errors++;
				return;
			end
			e = pending_hits.pop_front();
			cmp("hit", e.hit, a.hit);
			cmp("hit_distance", e.distance, a.distance);
			cmp("hit_x", e.px, a.px);
			cmp("hit_y", e.py, a.py);
			cmp("hit_z", e.pz, a.pz);
			cmp("facing_nx", e.nx, a.nx);
			cmp("facing_ny", e.ny, a.ny);
			cmp("facing_nz", e.nz, a.nz);
			cmp("hit_object", e.obj, a.obj);
			cmp("hit_material", e.mat, a.mat);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	rri_ray_if ray_bus();
	rri_res_if res_bus();

	ray_rectangle_intersect u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.ray(ray_bus.sink), .res(res_bus.source)
	);

	rect_scoreboard sb = new();
	int burst_left;
	int hold_req;
	int hold_left;
	int rx_mode;
	int rx_count;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver: switches at random among always ready, mostly ready and mostly stalled; a hold
	// request blocks it for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			hold_left = 0;
			rx_count = 0;
			rx_mode = 0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			rx_count++;
			if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else if (rx_mode == 0) begin
				res_bus.ready <= 1'b1;
			end else if (rx_mode == 1) begin
				res_bus.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				res_bus.ready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready)
			sb.check_result({res_bus.hit, res_bus.hit_distance, res_bus.hit_x, res_bus.hit_y,
				res_bus.hit_z, res_bus.facing_nx, res_bus.facing_ny, res_bus.facing_nz,
				res_bus.hit_object, res_bus.hit_material});
	end

	task automatic cfg_write(reg_e idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_ray(ray_t r);
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				ray_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		ray_bus.valid <= 1'b1;
		{ray_bus.origin_x, ray_bus.origin_y, ray_bus.origin_z, ray_bus.dir_x, ray_bus.dir_y,
			ray_bus.dir_z, ray_bus.nearest_distance} <= r;
		@(posedge clk);
		while (!ray_bus.ready) @(posedge clk);
		sb.note_ray(r);
	endtask

	task automatic drain();
		ray_bus.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic ray_t mk(int ox, int oy, int oz, int dx, int dy, int dz, int nd);
		ray_t r;
		r.ox = 16'(ox); r.oy = 16'(oy); r.oz = 16'(oz);
		r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
		r.nearest = 24'(nd);
		return r;
	endfunction

	// Ray aimed at a random point in or just around the rectangle.
	function automatic ray_t aimed_ray();
		longint s, t, travel, tgt, dir;
		int o[3], d[3];
		s = longint'($urandom_range(0, 2 * sb.half_u + 40)) - sb.half_u - 20;
		t = longint'($urandom_range(0, 2 * sb.half_v + 40)) - sb.half_v - 20;
		travel = $urandom_range(16, 5000);
		for (int i = 0; i < 3; i++) begin
			dir = longint'($urandom_range(0, 32767)) - 16384;
			tgt = sb.c[i] + ((s * sb.u[i]) >>> 14) + ((t * sb.v[i]) >>> 14);
			d[i] = int'(dir);
			o[i] = int'(rect_scoreboard::sat16(tgt - ((travel * dir) >>> 14)));
		end
		return mk(o[0], o[1], o[2], d[0], d[1], d[2],
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'h0FFFFF) : 24'hFFFFFF);
	endfunction

	task automatic load_rect(int ph);
		logic [47:0] c, n, u, v;
		logic [31:0] half;
		logic [15:0] obj, mat;
		logic [15:0] cx, cy, cz;
		cx = 16'($urandom_range(0, 16'h2000) - 16'h1000);
		cy = 16'($urandom_range(0, 16'h2000) - 16'h1000);
		cz = 16'($urandom_range(0, 16'h2000) - 16'h1000);
		half = {16'($urandom_range(1, 16'h1000)), 16'($urandom_range(1, 16'h1000))};
		obj = 16'($urandom);
		mat = 16'($urandom);
		case (ph)
			0: begin
				c = '0;
				n = {16'd16384, 16'd0, 16'd0};
				u = {16'd0, 16'd0, 16'd16384};
				v = {16'd0, 16'd16384, 16'd0};
				half = {16'h0400, 16'h0800};
				obj = 16'h1234;
				mat = 16'hABCD;
			end
			1: begin
				c = {cz, cy, cx};
				n = {16'd0, 16'd16384, 16'd0};
				u = {16'd16384, 16'd0, 16'd0};
				v = {16'd0, 16'd0, 16'd16384};
			end
			2: begin
				c = {cz, cy, cx};
				n = {16'd0, 16'd11585, 16'd11585};
				u = {16'd0, -16'sd11585, 16'd11585};
				v = {16'd16384, 16'd0, 16'd0};
			end
			3: begin
				c = {16'd0, 16'h8000, 16'h7FFF};
				n = {16'd0, 16'd0, 16'h8000};
				u = {16'd0, 16'd16384, 16'd0};
				v = {16'd16384, 16'd0, 16'd0};
				half = 32'hFFFF_FFFF;
				obj = 16'hFFFF;
				mat = 16'hFFFF;
			end
			4: begin
				c = '0;
				n = {16'd16384, 16'd0, 16'd0};
				u = {16'd0, 16'd0, 16'd16384};
				v = {16'd0, 16'd16384, 16'd0};
				half = '0;
				obj = '0;
				mat = '0;
			end
			default: begin
				c = 48'({$urandom, $urandom});
				n = 48'({$urandom, $urandom});
				u = 48'({$urandom, $urandom});
				v = 48'({$urandom, $urandom});
				half = $urandom;
			end
		endcase
		cfg_write(REG_CENTER, 64'(c));
		cfg_write(REG_NORMAL, 64'(n));
		cfg_write(REG_AXIS_U, 64'(u));
		cfg_write(REG_AXIS_V, 64'(v));
		cfg_write(REG_HALF, 64'(half));
		cfg_write(REG_OBJECT, 64'(obj));
		cfg_write(REG_MATERIAL, 64'(mat));
		cfg_write(REG_ENABLE, (ph == 6) ? 64'd0 : 64'd1);
	endtask

	initial begin
		ray_t r;
		int count;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ray_bus.valid = 1'b0;
		{ray_bus.origin_x, ray_bus.origin_y, ray_bus.origin_z, ray_bus.dir_x, ray_bus.dir_y,
			ray_bus.dir_z, ray_bus.nearest_distance} = '0;
		burst_left = 0;
		hold_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Rays against the reset configuration: block disabled.
		send_ray(mk(0, 0, 16'h0A00, 0, 0, -16384, 24'hFFFFFF));
		send_ray(mk(-32768, 32767, 0, 32767, -32768, 1, 24'hFFFFFF));
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			load_rect(ph);
			if (ph == 0) begin
				send_ray(mk(0, 0, 16'h0A00, 0, 0, -16384, 24'hFFFFFF));
				send_ray(mk(16'h0100, 16'h0200, -16'sh0A00, 0, 0, 16384, 24'hFFFFFF));
				send_ray(mk(0, 0, 16'h0A00, 16384, 0, 0, 24'hFFFFFF));
				send_ray(mk(0, 0, 16'h0A00, 0, 0, 2, 24'hFFFFFF));
				send_ray(mk(0, 0, 16'h0A00, 0, 0, 16384, 24'hFFFFFF));
				send_ray(mk(0, 0, 16'h0A00, 0, 0, -16384, 0));
				send_ray(mk(0, 0, 16'h0A00, 0, 0, -16384, 1));
				send_ray(mk(0, 0, 16'h0A00, 0, 0, -16384, 24'h00A000));
				send_ray(mk(0, 0, 16'h0A00, 0, 0, -16384, 24'h00A001));
				send_ray(mk(16'h0900, 0, 16'h0A00, 0, 0, -16384, 24'hFFFFFF));
				send_ray(mk(16'h0800, 16'h0400, 16'h0100, 0, 0, -16384, 24'hFFFFFF));
				send_ray(mk(-16'sh0800, -16'sh0400, 16'h0100, 0, 0, -16384, 24'hFFFFFF));
				send_ray(mk(32767, 32767, 32767, -32768, -32768, -32768, 24'hFFFFFF));
				send_ray(mk(-32768, -32768, -32768, 32767, 32767, 32767, 24'hFFFFFF));
				send_ray(mk(0, 0, 16'h0A00, 0, 0, 0, 24'hFFFFFF));
				send_ray(mk(16'h0100, 0, 0, 0, 0, -16384, 24'hFFFFFF));
				send_ray(mk(0, 0, 32767, 0, 0, -1, 24'hFFFFFF));
				send_ray(mk(0, 0, 1, 0, 0, -32768, 24'hFFFFFF));
				send_ray(mk(16'h0200, 16'h0100, 16'h0400, 8192, 4096, -16384, 24'hFFFFFF));
				send_ray(mk(0, 0, -16'sh0400, 16'h7FFF, 0, 16384, 24'hFFFFFF));
			end
			count = (ph == 6) ? 60 : 250;
			for (int k = 0; k < count; k++) begin
				// Receiver blocks long while rays keep coming, to fill the queue.
				if (ph == 2 && k == 50) hold_req = 300;
				// Sender stops until every outstanding result has arrived.
				if (ph == 3 && k == 120) drain();
				if ($urandom_range(0, 99) < 80) begin
					r = aimed_ray();
				end else begin
					r = 120'({$urandom, $urandom, $urandom, $urandom});
				end
				send_ray(r);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
